// ----- rtl/utf8v_pkg.sv -----
// Shared types and constants for the UTF-8 stream validator.
package utf8v_pkg;

  localparam int unsigned AccW = 21;

  // Byte class boundaries
  localparam logic [7:0] ByteAsciiEnd = 8'h80;
  localparam logic [7:0] ByteCtrlEnd  = 8'h20;
  localparam logic [7:0] ByteDel      = 8'h7f;
  localparam logic [7:0] ByteNul      = 8'h00;
  localparam logic [7:0] Lead2Lo      = 8'hc2;
  localparam logic [7:0] Lead2Hi      = 8'hdf;
  localparam logic [7:0] Lead3Lo      = 8'he0;
  localparam logic [7:0] Lead3Hi      = 8'hef;
  localparam logic [7:0] Lead4Lo      = 8'hf0;
  localparam logic [7:0] Lead4Hi      = 8'hf4;
  localparam logic [7:0] ContMask     = 8'hc0;
  localparam logic [7:0] ContTag      = 8'h80;

  // Code point limits
  localparam logic [AccW-1:0] CpMin3    = 21'h000800;
  localparam logic [AccW-1:0] CpMin4    = 21'h010000;
  localparam logic [AccW-1:0] CpMax     = 21'h10ffff;
  localparam logic [AccW-1:0] CpSurrLo  = 21'h00d800;
  localparam logic [AccW-1:0] CpSurrHi  = 21'h00dfff;

  // Sequence kinds (continuation count of the open sequence)
  localparam logic [1:0] KindNone = 2'd0;
  localparam logic [1:0] Kind2    = 2'd1;
  localparam logic [1:0] Kind3    = 2'd2;
  localparam logic [1:0] Kind4    = 2'd3;

  // Per-string decode state
  typedef struct packed {
    logic            error_seen;
    logic [1:0]      bytes_pending;
    logic [1:0]      sequence_kind;
    logic [AccW-1:0] code_acc;
  } str_state_t;

endpackage

// ----- rtl/utf8v_step.sv -----
// Single-byte decode step: next string state from current state and one byte.
module utf8v_step (
  input  utf8v_pkg::str_state_t state_i,
  input  logic [7:0]            byte_i,
  input  logic                  ctrl_reject_i,
  output utf8v_pkg::str_state_t state_o
);
  import utf8v_pkg::*;

  localparam str_state_t ErrState = '{error_seen: 1'b1, bytes_pending: 2'd0,
                                      sequence_kind: KindNone, code_acc: '0};

  logic [AccW-1:0] acc_shift;
  logic [1:0]      pend_dec;
  logic            cp_bad;
  logic            ctrl_bad;

  // Continuation path: shift in six payload bits
  assign acc_shift = {state_i.code_acc[AccW-7:0], byte_i[5:0]};
  assign pend_dec  = state_i.bytes_pending - 2'd1;

  // Final code point checks: overlong, out of range, surrogate
  assign cp_bad = (state_i.sequence_kind == Kind3 && acc_shift < CpMin3) ||
                  (state_i.sequence_kind == Kind4 && acc_shift < CpMin4) ||
                  (acc_shift > CpMax) ||
                  (acc_shift >= CpSurrLo && acc_shift <= CpSurrHi);

  // ASCII rejects: NUL always, controls and DEL when enabled
  assign ctrl_bad = (byte_i == ByteNul) ||
                    (ctrl_reject_i && (byte_i < ByteCtrlEnd || byte_i == ByteDel));

  always_comb begin
    state_o = state_i;
    if (state_i.error_seen) begin
      state_o = state_i;
    end else if (state_i.bytes_pending == 2'd0) begin
      // Lead byte
      priority if (byte_i < ByteAsciiEnd) begin
        if (ctrl_bad) state_o = ErrState;
      end else if (byte_i >= Lead2Lo && byte_i <= Lead2Hi) begin
        state_o.bytes_pending = 2'd1;
        state_o.sequence_kind = Kind2;
        state_o.code_acc      = {{(AccW-5){1'b0}}, byte_i[4:0]};
      end else if (byte_i >= Lead3Lo && byte_i <= Lead3Hi) begin
        state_o.bytes_pending = 2'd2;
        state_o.sequence_kind = Kind3;
        state_o.code_acc      = {{(AccW-4){1'b0}}, byte_i[3:0]};
      end else if (byte_i >= Lead4Lo && byte_i <= Lead4Hi) begin
        state_o.bytes_pending = 2'd3;
        state_o.sequence_kind = Kind4;
        state_o.code_acc      = {{(AccW-3){1'b0}}, byte_i[2:0]};
      end else begin
        state_o = ErrState;
      end
    end else begin
      // Continuation byte
      priority if ((byte_i & ContMask) != ContTag) begin
        state_o = ErrState;
      end else if (pend_dec != 2'd0) begin
        state_o.bytes_pending = pend_dec;
        state_o.code_acc      = acc_shift;
      end else if (cp_bad) begin
        state_o = ErrState;
      end else begin
        state_o.bytes_pending = 2'd0;
        state_o.sequence_kind = KindNone;
        state_o.code_acc      = '0;
      end
    end
  end

endmodule

// ----- rtl/utf8_stream_validator_top.sv -----
// Top level of the UTF-8 stream validator: input stage, string state, result stage.
// Takes one byte beat per clock while in_stall_o is low. A beat is registered at the
// input, decoded in the next cycle against the string state register, and the verdict
// of a string is loaded into the output register when its last byte leaves the input
// register. Without stalls, the throughput of one byte per cycle is set by the string state
// register, which is updated once per byte. The input stalls only when a last-byte verdict
// cannot enter the output register because a previous verdict is still held. The
// control-reject setting resets to 1 and should be written between strings.
module utf8_stream_validator_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       valid_res_o
);
  import utf8v_pkg::*;

  logic       ctrl_reject_q;
  logic       s1_valid_q, s1_valid_d;
  logic [7:0] s1_byte_q;
  logic       s1_last_q;
  logic       s1_fire;
  logic       in_fire;
  logic       out_valid_q, out_valid_d;
  logic       res_q;
  str_state_t state_q, state_d, step_state;

  // Config register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_reject_q <= 1'b1;
    end else if (cfg_we_i) begin
      ctrl_reject_q <= cfg_wdata_i;
    end
  end

  // Stage 1 may move on unless it carries a verdict that the output cannot take
  assign s1_fire    = s1_valid_q && (!s1_last_q || !out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_fire;
  assign in_fire    = in_valid_i && !in_stall_o;
  assign s1_valid_d = in_fire || (s1_valid_q && !s1_fire);

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_byte_q <= data_byte_i;
      s1_last_q <= last_byte_i;
    end
  end

  // Decode step
  utf8v_step u_step (
    .state_i       (state_q),
    .byte_i        (s1_byte_q),
    .ctrl_reject_i (ctrl_reject_q),
    .state_o       (step_state)
  );

  // String state: clears after the last byte
  always_comb begin
    state_d = state_q;
    if (s1_fire) begin
      state_d = s1_last_q ? str_state_t'('0) : step_state;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else begin
      state_q <= state_d;
    end
  end

  // Result register
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (s1_fire && s1_last_q) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && s1_last_q) begin
      res_q <= !step_state.error_seen && (step_state.bytes_pending == 2'd0);
    end
  end

  assign out_valid_o = out_valid_q;
  assign valid_res_o = res_q;

  // Checks
  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && s1_last_q) |=> (state_q == str_state_t'('0)))
    else $error("string state not cleared after last byte");

  a_err_no_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.error_seen |-> (state_q.bytes_pending == 2'd0 && state_q.code_acc == '0))
    else $error("error state holds a partial sequence");

  a_pend_le_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.bytes_pending <= state_q.sequence_kind)
    else $error("pending count exceeds sequence length");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !$past(out_valid_q)) |-> $past(s1_fire && s1_last_q))
    else $error("verdict without a last byte");

endmodule
